// ----- rtl/ffsa_pkg.sv -----
// Shared types and constants for the first-fit segment allocator.
// Used by every module in rtl/; has no dependencies.
package ffsa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SIZE_BITS    = 32;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam logic [SIZE_BITS-1:0] CAP_RESET = '1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NO_SPACE   = 2'd1,
    STS_TABLE_FULL = 2'd2,
    STS_NOT_FOUND  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_PASS,
    ST_PUSH,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // One table slot; an invalid slot is a hole and is skipped by every walk
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 owned;
    logic [SIZE_BITS-1:0] size;
  } seg_entry_t;

  // Ring control from the head unit to every cell
  typedef struct packed {
    logic shift;
    logic init;
  } ring_ctl_t;

endpackage

// ----- rtl/ffsa_cell.sv -----
// One slot of the segment ring: holds an entry and takes its neighbor's on shift.
// Depends on ffsa_pkg.
module ffsa_cell import ffsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ring_ctl_t  ctl,
  input  seg_entry_t init_entry,
  input  seg_entry_t shift_in,
  output seg_entry_t entry
);

  // Load the initial table on reset or capacity write, else advance the ring
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      entry <= init_entry;
    end else if (ctl.shift) begin
      entry <= shift_in;
    end
  end

endmodule

// ----- rtl/ffsa_head.sv -----
// Head unit of the segment ring: command sequencer, walk logic, split carry,
// coalescing and result register. Depends on ffsa_pkg.
module ffsa_head import ffsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [SIZE_BITS-1:0] in_request_size,
  input  logic [SIZE_BITS-1:0] in_release_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [SIZE_BITS-1:0] out_granted_offset,
  output logic [SIZE_BITS-1:0] out_bytes_in_use,
  input  logic                 cfg_wr_en,
  input  logic [SIZE_BITS-1:0] cfg_wr_data,
  input  seg_entry_t           head_in,
  output seg_entry_t           head_out,
  output ring_ctl_t            ring_ctl
);

  state_t               state, state_next;
  cmd_t                 cmd, cmd_next;
  logic [SIZE_BITS-1:0] req, req_next;
  logic [SIZE_BITS-1:0] off, off_next;
  logic [SIZE_BITS-1:0] cap;
  logic [SIZE_BITS-1:0] owned_total, owned_total_next;
  logic [CNT_W-1:0]     seg_count, seg_count_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [SIZE_BITS-1:0] run, run_next;
  logic                 hit, hit_next;
  seg_entry_t           carry, carry_next;
  seg_entry_t           pend, pend_next;
  status_t              sts, sts_next;
  logic [SIZE_BITS-1:0] granted, granted_next;
  logic [SIZE_BITS-1:0] left;
  logic                 last;
  logic                 take_result;
  seg_entry_t           rel;

  assign in_ready    = (state == ST_IDLE);
  assign left        = (cap >= owned_total) ? (cap - owned_total) : '0;
  assign last        = (idx == IDX_W'(MAX_SEGMENTS - 1));
  assign take_result = (state == ST_DONE) && (!out_valid || out_ready);

  // Sequencer state and working registers
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      state       <= ST_IDLE;
      owned_total <= '0;
      seg_count   <= CNT_W'(1);
      hit         <= 1'b0;
      carry       <= '0;
      pend        <= '0;
    end else begin
      state       <= state_next;
      owned_total <= owned_total_next;
      seg_count   <= seg_count_next;
      hit         <= hit_next;
      carry       <= carry_next;
      pend        <= pend_next;
    end
    cmd     <= cmd_next;
    req     <= req_next;
    off     <= off_next;
    idx     <= idx_next;
    run     <= run_next;
    sts     <= sts_next;
    granted <= granted_next;
  end

  // Hold the heap capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  // Result register, parted from the command side
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      out_valid <= 1'b0;
    end else if (take_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (take_result) begin
      out_status         <= sts;
      out_granted_offset <= granted;
      out_bytes_in_use   <= owned_total;
    end
  end

  // Walk the ring one entry per cycle
  always_comb begin
    state_next       = state;
    cmd_next         = cmd;
    req_next         = req;
    off_next         = off;
    owned_total_next = owned_total;
    seg_count_next   = seg_count;
    idx_next         = idx;
    run_next         = run;
    hit_next         = hit;
    carry_next       = carry;
    pend_next        = pend;
    sts_next         = sts;
    granted_next     = granted;
    head_out         = head_in;
    ring_ctl.shift   = 1'b0;
    ring_ctl.init    = cfg_wr_en;
    rel              = head_in;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_next     = cmd_t'(in_command);
          req_next     = in_request_size;
          off_next     = in_release_offset;
          idx_next     = '0;
          run_next     = '0;
          hit_next     = 1'b0;
          carry_next   = '0;
          pend_next    = '0;
          granted_next = '1;
          if (cmd_t'(in_command) == CMD_ALLOC) begin
            sts_next = STS_NO_SPACE;
            if (in_request_size == '0 || in_request_size > left) begin
              state_next = ST_DONE;
            end else begin
              state_next = ST_SEEK;
            end
          end else begin
            sts_next   = STS_NOT_FOUND;
            state_next = ST_SEEK;
          end
        end
      end

      // Rotate until the table head sits at the ring head
      ST_SEEK: begin
        if (head_in.first) begin
          state_next = ST_PASS;
        end else begin
          ring_ctl.shift = 1'b1;
        end
      end

      ST_PASS: begin
        ring_ctl.shift = 1'b1;
        idx_next       = idx + IDX_W'(1);
        if (cmd == CMD_ALLOC) begin
          if (carry.valid) begin
            // Push entries one slot back until a hole absorbs the carry
            head_out   = carry;
            carry_next = head_in.valid ? head_in : '0;
          end else if (!hit && head_in.valid && !head_in.owned && head_in.size >= req) begin
            hit_next = 1'b1;
            if (head_in.size == req) begin
              head_out.owned   = 1'b1;
              owned_total_next = owned_total + req;
              sts_next         = STS_OK;
              granted_next     = run;
            end else if (seg_count == CNT_W'(MAX_SEGMENTS)) begin
              sts_next = STS_TABLE_FULL;
            end else begin
              head_out.owned   = 1'b1;
              head_out.size    = req;
              carry_next       = '{valid: 1'b1, first: 1'b0, owned: 1'b0,
                                   size: head_in.size - req};
              seg_count_next   = seg_count + CNT_W'(1);
              owned_total_next = owned_total + req;
              sts_next         = STS_OK;
              granted_next     = run;
            end
          end else if (!hit && head_in.valid) begin
            run_next = run + head_in.size;
          end
          if (last) begin
            state_next = carry_next.valid ? ST_PUSH : ST_DONE;
          end
        end else begin
          // Release the segment at the offset, then merge with the pending one
          if (!hit && head_in.valid) begin
            if (run == off) begin
              hit_next = 1'b1;
              if (head_in.owned) begin
                rel.owned        = 1'b0;
                owned_total_next = owned_total - head_in.size;
                sts_next         = STS_OK;
              end
            end else begin
              run_next = run + head_in.size;
            end
          end
          if (rel.valid) begin
            if (pend.valid && !pend.owned && !rel.owned) begin
              pend_next.size = pend.size + rel.size;
              head_out       = '0;
              seg_count_next = seg_count - CNT_W'(1);
            end else begin
              head_out  = pend;
              pend_next = rel;
            end
          end else begin
            head_out = '0;
          end
          if (last) begin
            state_next = ST_FLUSH;
          end
        end
      end

      // Carry wraps past the end of the table until a hole takes it
      ST_PUSH: begin
        ring_ctl.shift = 1'b1;
        head_out       = carry;
        carry_next     = head_in.valid ? head_in : '0;
        if (!head_in.valid) begin
          state_next = ST_DONE;
        end
      end

      // Drop the leading hole left by the merge pass and write the last entry
      ST_FLUSH: begin
        ring_ctl.shift = 1'b1;
        head_out       = pend;
        pend_next      = '0;
        state_next     = ST_DONE;
      end

      ST_DONE: begin
        if (take_result) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_flush_hole: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> !head_in.valid)
    else $error("merge pass did not leave a hole at the ring head");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    seg_count != '0 && seg_count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_push_carry: assert property (@(posedge clk) disable iff (rst)
    state == ST_PUSH |-> carry.valid)
    else $error("push state without a carried entry");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst || cfg_wr_en)
    in_valid && in_ready |=> state != ST_IDLE)
    else $error("accepted request did not start");

endmodule

// ----- rtl/first_fit_segment_allocator.sv -----
// Top level of the first-fit segment allocator: ring of segment cells plus head unit.
// Depends on ffsa_pkg, ffsa_cell and ffsa_head.
//
// Usage:
//   Requests enter on s_axis (tuser = command, tdata = request_size and
//   release_offset), one result per request leaves on m_axis (tuser = status,
//   tdata = granted_offset and bytes_in_use). cfg_wr_en/cfg_wr_data write the
//   heap capacity and reinitialize the table to one free segment; write it
//   only while no request is in flight.
//   The segment table lives in a ring of MAX_SEGMENTS cells that rotates one
//   slot per cycle through the head unit while a request is in progress. A
//   request first rotates the ring until the table head is at the ring head,
//   then walks every slot once. A split that pushes entries past the end of
//   the ring wraps on until a hole takes the carry; a free ends with a flush
//   step. An allocate rejected for size goes straight to its result without
//   a walk. Requests are handled one at a time.
//   A new request is taken while the previous result still waits on m_axis;
//   a stalled receiver only holds the finished request in its last state.
//   Reset sets the capacity to all ones and the table to one free segment.
module first_fit_segment_allocator import ffsa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [2*SIZE_BITS-1:0] s_axis_tdata,  // request_size, release_offset
  input  logic                   s_axis_tuser,  // command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [2*SIZE_BITS-1:0] m_axis_tdata,  // granted_offset, bytes_in_use
  output logic [1:0]             m_axis_tuser,  // status
  input  logic                   cfg_wr_en,
  input  logic [SIZE_BITS-1:0]   cfg_wr_data
);

  seg_entry_t cell_q [MAX_SEGMENTS];
  seg_entry_t head_out;
  seg_entry_t init0;
  ring_ctl_t  ring_ctl;

  // Table head after reset or capacity write
  assign init0 = '{valid: 1'b1, first: 1'b1, owned: 1'b0,
                   size: rst ? CAP_RESET : cfg_wr_data};

  // Build the ring: each cell takes its right neighbor, the last one the head output
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    if (i == MAX_SEGMENTS - 1) begin : g_tail
      ffsa_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ring_ctl),
        .init_entry((i == 0) ? init0 : seg_entry_t'('0)),
        .shift_in  (head_out),
        .entry     (cell_q[i])
      );
    end else begin : g_body
      ffsa_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ring_ctl),
        .init_entry((i == 0) ? init0 : seg_entry_t'('0)),
        .shift_in  (cell_q[i+1]),
        .entry     (cell_q[i])
      );
    end
  end

  ffsa_head u_head (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .in_command        (s_axis_tuser),
    .in_request_size   (s_axis_tdata[SIZE_BITS-1:0]),
    .in_release_offset (s_axis_tdata[2*SIZE_BITS-1:SIZE_BITS]),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_status        (m_axis_tuser),
    .out_granted_offset(m_axis_tdata[SIZE_BITS-1:0]),
    .out_bytes_in_use  (m_axis_tdata[2*SIZE_BITS-1:SIZE_BITS]),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .head_in           (cell_q[0]),
    .head_out          (head_out),
    .ring_ctl          (ring_ctl)
  );

endmodule

// ----- test/heap_table_checker.sv -----
// Checker for the first-fit segment allocator: mirrors the segment table,
// predicts one result per request and compares it with m_axis. Uses ffsa_pkg.
module heap_table_checker import ffsa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [2*SIZE_BITS-1:0] s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [2*SIZE_BITS-1:0] m_axis_tdata,
  input  logic [1:0]             m_axis_tuser,
  input  logic                   cfg_wr_en,
  input  logic [SIZE_BITS-1:0]   cfg_wr_data,
  output int                     fail_count,
  output int                     outstanding,
  output int                     checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t        status;
    logic [31:0]    granted;
    logic [31:0]    in_use;
  } heap_result_t;

  heap_result_t pending_results[$];

  // Mirror of the segment table
  logic [SIZE_BITS-1:0] capacity;
  logic [SIZE_BITS-1:0] seg_size [MAX_SEGMENTS];
  logic                 seg_owned[MAX_SEGMENTS];
  int                   seg_count;
  logic [SIZE_BITS-1:0] owned_total;

  function automatic void reset_table(logic [SIZE_BITS-1:0] cap);
    capacity = cap;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_size[i] = '0;
      seg_owned[i] = 1'b0;
    end
    seg_size[0] = cap;
    seg_count = 1;
    owned_total = '0;
  endfunction

  // Collapse every run of neighboring free segments into one
  function automatic void merge_free_runs();
    int w;
    w = 0;
    for (int r = 0; r < seg_count; r++) begin
      if (w > 0 && !seg_owned[r] && !seg_owned[w-1]) begin
        seg_size[w-1] = seg_size[w-1] + seg_size[r];
      end else begin
        seg_size[w] = seg_size[r];
        seg_owned[w] = seg_owned[r];
        w++;
      end
    end
    seg_count = w;
  endfunction

  function automatic status_t predict_allocate(logic [SIZE_BITS-1:0] req,
                                               output logic [SIZE_BITS-1:0] offset);
    logic [SIZE_BITS-1:0] left;
    logic [SIZE_BITS-1:0] cur;
    cur = '0;
    offset = '1;
    left = (capacity >= owned_total) ? capacity - owned_total : '0;
    if (req == 0 || req > left) return STS_NO_SPACE;
    for (int i = 0; i < seg_count; i++) begin
      if (seg_owned[i] || seg_size[i] < req) begin
        cur = cur + seg_size[i];
      end else begin
        if (seg_size[i] == req) begin
          seg_owned[i] = 1'b1;
        end else begin
          if (seg_count >= MAX_SEGMENTS) return STS_TABLE_FULL;
          for (int k = seg_count; k > i; k--) begin
            seg_size[k] = seg_size[k-1];
            seg_owned[k] = seg_owned[k-1];
          end
          seg_size[i+1] = seg_size[i] - req;
          seg_owned[i+1] = 1'b0;
          seg_size[i] = req;
          seg_owned[i] = 1'b1;
          seg_count++;
        end
        owned_total = owned_total + req;
        offset = cur;
        return STS_OK;
      end
    end
    return STS_NO_SPACE;
  endfunction

  function automatic status_t predict_release(logic [SIZE_BITS-1:0] off);
    logic [SIZE_BITS-1:0] cur;
    status_t st;
    cur = '0;
    st = STS_NOT_FOUND;
    for (int i = 0; i < seg_count; i++) begin
      if (cur == off) begin
        if (seg_owned[i]) begin
          seg_owned[i] = 1'b0;
          owned_total = owned_total - seg_size[i];
          st = STS_OK;
        end
        break;
      end
      cur = cur + seg_size[i];
    end
    merge_free_runs();
    return st;
  endfunction

  assign outstanding = pending_results.size();

  // Compare results first, then predict the newly accepted request
  always @(posedge clk) begin
    heap_result_t exp_r;
    logic [SIZE_BITS-1:0] offset;
    if (rst) begin
      reset_table(CAP_RESET);
      pending_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked++;
        if (pending_results.size() == 0) begin
          $error("result with no request waiting: tuser=%0d tdata=%h",
                 m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (m_axis_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[31:0] !== exp_r.granted) begin
            $error("granted_offset: expected %h, got %h", exp_r.granted,
                   m_axis_tdata[31:0]);
            fail_count++;
          end
          if (m_axis_tdata[63:32] !== exp_r.in_use) begin
            $error("bytes_in_use: expected %h, got %h", exp_r.in_use,
                   m_axis_tdata[63:32]);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_ALLOC) begin
          exp_r.status = predict_allocate(s_axis_tdata[31:0], offset);
          exp_r.granted = (exp_r.status == STS_OK) ? offset : '1;
        end else begin
          exp_r.status = predict_release(s_axis_tdata[63:32]);
          exp_r.granted = '1;
        end
        exp_r.in_use = owned_total;
        pending_results.push_back(exp_r);
      end
      if (cfg_wr_en) reset_table(cfg_wr_data);
    end
  end

  final begin
    if (pending_results.size() != 0)
      $display("%0d results never arrived", pending_results.size());
  end
endmodule

// ----- test/tb.sv -----
// Testbench top for the first-fit segment allocator: clock, reset, request
// stimulus over several heap capacities and the verdict. Uses heap_table_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffsa_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*SIZE_BITS-1:0] s_axis_tdata = '0;  // request_size, release_offset
  logic                   s_axis_tuser = 1'b0; // command
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [2*SIZE_BITS-1:0] m_axis_tdata;       // granted_offset, bytes_in_use
  logic [1:0]             m_axis_tuser;       // status
  logic                   cfg_wr_en = 1'b0;
  logic [SIZE_BITS-1:0]   cfg_wr_data = '0;

  int fail_count, outstanding, checked;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;
  int cap_settings = 0;
  logic [31:0] live_offsets[$];

  first_fit_segment_allocator uut (.*);
  heap_table_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Throttle the result side
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Collect granted offsets so frees can hit owned segments
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready && m_axis_tuser == STS_OK &&
        m_axis_tdata[31:0] != '1)
      live_offsets.push_back(m_axis_tdata[31:0]);
  end

  task automatic send_request(cmd_t cmd, logic [31:0] size, logic [31:0] off);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {off, size};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // Drain, let the walk finish, then write the capacity
  task automatic write_capacity(logic [31:0] cap);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    live_offsets.delete();
    cap_settings++;
    @(posedge clk);
  endtask

  task automatic random_request(logic [31:0] cap, int alloc_pct);
    int pick, idx;
    logic [31:0] lim;
    pick = $urandom_range(0, 99);
    lim = cap / 20 + 1;
    if ($urandom_range(0, 99) < alloc_pct) begin
      if (pick < 80) send_request(CMD_ALLOC, $urandom_range(1, lim), $urandom);
      else if (pick < 85) send_request(CMD_ALLOC, 32'd0, $urandom);
      else if (pick < 90) send_request(CMD_ALLOC, $urandom, $urandom);
      else send_request(CMD_ALLOC, $urandom_range(1, (cap == 0) ? 1 : cap), $urandom);
    end else begin
      if (pick < 80 && live_offsets.size() > 0) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        send_request(CMD_FREE, $urandom, live_offsets[idx]);
        live_offsets.delete(idx);
      end else if (pick < 90) begin
        send_request(CMD_FREE, $urandom, $urandom);
      end else begin
        send_request(CMD_FREE, $urandom, $urandom_range(0, lim));
      end
    end
  endtask

  initial begin
    logic [31:0] caps[8];
    int per_phase;
    caps = '{32'd1000, 32'd64, 32'hFFFF_FFFF, 32'd5000, 32'd0, 32'd1000, 32'd300, 32'd1};
    caps[4] = $urandom;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes at the reset capacity
    send_request(CMD_ALLOC, 32'd0, 32'd0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(CMD_ALLOC, 32'd1, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'd5);
    send_request(CMD_ALLOC, 32'h8000_0000, 32'd0);
    send_request(CMD_ALLOC, 32'h7FFF_FFFF, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'h8000_0000);
    send_request(CMD_FREE, 32'd0, 32'hFFFF_FFFF);
    // Empty heap rejects everything
    write_capacity(32'd0);
    send_request(CMD_ALLOC, 32'd1, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'd0);
    // Smallest heap
    write_capacity(32'd1);
    send_request(CMD_ALLOC, 32'd1, 32'd0);
    send_request(CMD_ALLOC, 32'd1, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'd0);
    // Fragmented heap: enough free bytes, no single segment fits
    write_capacity(32'd100);
    send_request(CMD_ALLOC, 32'd30, 32'd0);
    send_request(CMD_ALLOC, 32'd30, 32'd0);
    send_request(CMD_ALLOC, 32'd30, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'd60);
    send_request(CMD_ALLOC, 32'd50, 32'd0);
    send_request(CMD_FREE, 32'd0, 32'd0);
    send_request(CMD_ALLOC, 32'd70, 32'd0);

    // Random phases, idling pattern changes with progress
    per_phase = 206;
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      for (int n = 0; n < per_phase; n++) begin
        if (sent < 575) begin
          send_idle_pct = 20;
          recv_stall_pct = 45;
        end else if (sent < 1125) begin
          send_idle_pct = 45;
          recv_stall_pct = 20;
        end else begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        // Alloc-heavy first half fills the table, then mostly frees
        random_request(caps[p], (n < per_phase / 2) ? 85 : 45);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("Sent %0d requests over %0d capacity writes; %0d results checked.",
             sent, cap_settings, checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/ffsa_pkg.sv
rtl/ffsa_cell.sv
rtl/ffsa_head.sv
rtl/first_fit_segment_allocator.sv
test/heap_table_checker.sv
test/tb.sv
